/* hw/rtl/apt_pkg.sv */
// Package for the affine point transform: payload types, register codes,
// and single-precision multiply and add helpers shared by the lanes.
// No dependencies.
package apt_pkg;

	localparam int NumRegs  = 6;
	localparam int NumLanes = 3;
	localparam int RegW     = 64;
	localparam int IdxW     = 3;
	localparam logic [31:0] CanonNan = 32'h7FC00000;

	localparam logic [IdxW-1:0] RegRow0C01 = 3'd0;
	localparam logic [IdxW-1:0] RegRow0C23 = 3'd1;
	localparam logic [IdxW-1:0] RegRow1C01 = 3'd2;
	localparam logic [IdxW-1:0] RegRow1C23 = 3'd3;
	localparam logic [IdxW-1:0] RegRow2C01 = 3'd4;
	localparam logic [IdxW-1:0] RegRow2C23 = 3'd5;

	localparam logic [RegW-1:0] RstRow0C01 = 64'h000000003F800000;
	localparam logic [RegW-1:0] RstRow0C23 = 64'h0;
	localparam logic [RegW-1:0] RstRow1C01 = 64'h3F80000000000000;
	localparam logic [RegW-1:0] RstRow1C23 = 64'h0;
	localparam logic [RegW-1:0] RstRow2C01 = 64'h0;
	localparam logic [RegW-1:0] RstRow2C23 = 64'h000000003F800000;

	typedef struct packed {
		logic [31:0] in_x;
		logic [31:0] in_y;
		logic [31:0] in_z;
		logic        skip_translation;
	} in_item_t;

	typedef struct packed {
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic [31:0] out_z;
	} out_item_t;

	// one matrix row: columns 0..3
	typedef struct packed {
		logic [31:0] m3;
		logic [31:0] m2;
		logic [31:0] m1;
		logic [31:0] m0;
	} row_t;

	// Round a magnitude to single. mant holds the value mant * 2^(e-150) with
	// an unsigned 50-bit integer mant (at most bit 49 set) and e biased.
	// Returns the packed result with the given sign; sticky adds below mant.
	function automatic logic [31:0] fp_round(input logic sgn, input logic signed [11:0] e,
		input logic [49:0] mant, input logic sticky);
		logic [5:0]  lz;
		logic        found;
		logic [49:0] norm;
		logic signed [11:0] ex;
		logic [5:0]  sh;
		logic [75:0] wide;
		logic [23:0] keep;
		logic        g;
		logic        st;
		logic [24:0] rnd;
		logic [31:0] res;
		lz = 6'd0;
		found = 1'b0;
		for (int i = 49; i >= 0; i--) begin
			if (!found && mant[i]) begin
				found = 1'b1;
				lz = 6'(49 - i);
			end
		end
		if (!found) begin
			res = {sgn, 31'd0};
		end else begin
			norm = mant << lz;
			// leading one at bit 49 -> value = 1.f * 2^(e + 26 - lz - 127) roughly
			ex = e + 12'sd26 - $signed({6'd0, lz});
			if (ex < 12'sd1) begin
				sh = (ex < -12'sd30) ? 6'd31 : 6'(12'sd1 - ex);
				ex = 12'sd0;
			end else begin
				sh = 6'd0;
			end
			wide = {norm, 26'd0} >> sh;
			keep = wide[75:52];
			g = wide[51];
			st = (|wide[50:0]) | sticky;
			rnd = {1'b0, keep} + 25'(g & (st | keep[0]));
			if (rnd[24]) begin
				ex = ex + 12'sd1;
				rnd = rnd >> 1;
			end else if (ex == 12'sd0 && rnd[23]) begin
				ex = 12'sd1;
			end
			if (ex >= 12'sd255)
				res = {sgn, 8'hFF, 23'd0};
			else
				res = {sgn, ex[7:0], rnd[22:0]};
		end
		return res;
	endfunction

	function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
		logic        sgn;
		logic [7:0]  ea;
		logic [7:0]  eb;
		logic [23:0] ma;
		logic [23:0] mb;
		logic [47:0] p;
		logic signed [11:0] e;
		logic        an;
		logic        bn;
		logic        ai;
		logic        bi;
		logic        az;
		logic        bz;
		logic [31:0] res;
		sgn = a[31] ^ b[31];
		ea = a[30:23];
		eb = b[30:23];
		an = (ea == 8'hFF) && (a[22:0] != 0);
		bn = (eb == 8'hFF) && (b[22:0] != 0);
		ai = (ea == 8'hFF) && (a[22:0] == 0);
		bi = (eb == 8'hFF) && (b[22:0] == 0);
		az = (a[30:0] == 0);
		bz = (b[30:0] == 0);
		ma = {(ea != 0), a[22:0]};
		mb = {(eb != 0), b[22:0]};
		if (an || bn || (ai && bz) || (bi && az)) begin
			res = CanonNan;
		end else if (ai || bi) begin
			res = {sgn, 8'hFF, 23'd0};
		end else if (az || bz) begin
			res = {sgn, 31'd0};
		end else begin
			p = ma * mb;
			// p * 2^(ea'+eb'-300); fp_round wants mant*2^(e-150) => e = ea'+eb'-150
			e = $signed({4'd0, (ea == 0) ? 8'd1 : ea}) + $signed({4'd0, (eb == 0) ? 8'd1 : eb})
				- 12'sd150;
			res = fp_round(sgn, e, {2'b00, p}, 1'b0);
		end
		return res;
	endfunction

	function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
		logic [7:0]  ea;
		logic [7:0]  eb;
		logic [7:0]  el;
		logic [7:0]  es;
		logic [26:0] ml;
		logic [26:0] ms;
		logic        sl;
		logic        ss;
		logic [7:0]  d;
		logic [26:0] msh;
		logic        stk;
		logic [27:0] sum;
		logic        an;
		logic        bn;
		logic        ai;
		logic        bi;
		logic        swap;
		logic [31:0] res;
		ea = a[30:23];
		eb = b[30:23];
		an = (ea == 8'hFF) && (a[22:0] != 0);
		bn = (eb == 8'hFF) && (b[22:0] != 0);
		ai = (ea == 8'hFF) && (a[22:0] == 0);
		bi = (eb == 8'hFF) && (b[22:0] == 0);
		if (an || bn || (ai && bi && (a[31] != b[31]))) begin
			res = CanonNan;
		end else if (ai) begin
			res = a;
		end else if (bi) begin
			res = b;
		end else if (a[30:0] == 0 && b[30:0] == 0) begin
			res = {a[31] & b[31], 31'd0};
		end else begin
			swap = (b[30:0] > a[30:0]);
			el = swap ? eb : ea;
			es = swap ? ea : eb;
			sl = swap ? b[31] : a[31];
			ss = swap ? a[31] : b[31];
			ml = {(el != 0), (swap ? b[22:0] : a[22:0]), 3'b000};
			ms = {(es != 0), (swap ? a[22:0] : b[22:0]), 3'b000};
			if (el == 0) el = 8'd1;
			if (es == 0) es = 8'd1;
			d = el - es;
			if (d > 8'd27) begin
				msh = 27'd0;
				stk = (ms != 0);
			end else begin
				msh = ms >> d;
				stk = ((msh << d) != ms);
			end
			// sticky below the guard bits: fold into lsb (d>=2 when stk set)
			msh[0] = msh[0] | stk;
			if (sl == ss)
				sum = {1'b0, ml} + {1'b0, msh};
			else
				sum = {1'b0, ml} - {1'b0, msh};
			if (sum == 0)
				res = 32'd0;
			else
				// sum * 2^(el-127-26) ; fp_round: mant*2^(e-150) => e = el-3
				res = fp_round(sl, $signed({4'd0, el}) - 12'sd3, {22'd0, sum}, 1'b0);
		end
		return res;
	endfunction

endpackage

/* hw/rtl/apt_lane.sv */
// One row lane: three multiplies and three adds over four pipeline stages.
// Depends on apt_pkg for the float helpers and row type.
module apt_lane (
	input  logic            clk,
	input  logic            en,
	input  apt_pkg::row_t   row,
	input  apt_pkg::in_item_t pt,
	output logic [31:0]     res
);
	logic [31:0] p0_s1, p1_s1, p2_s1, m3_s1;
	logic [31:0] s01_s2, p2_s2, m3_s2;
	logic [31:0] s012_s3, m3_s3;
	logic        skip_s1, skip_s2, skip_s3;

	// multiply stage, then the sums in file order
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1   <= apt_pkg::fp_mul(row.m0, pt.in_x);
			p1_s1   <= apt_pkg::fp_mul(row.m1, pt.in_y);
			p2_s1   <= apt_pkg::fp_mul(row.m2, pt.in_z);
			m3_s1   <= row.m3;
			skip_s1 <= pt.skip_translation;
			s01_s2  <= apt_pkg::fp_add(p0_s1, p1_s1);
			p2_s2   <= p2_s1;
			m3_s2   <= m3_s1;
			skip_s2 <= skip_s1;
			s012_s3 <= apt_pkg::fp_add(p2_s2, s01_s2);
			m3_s3   <= m3_s2;
			skip_s3 <= skip_s2;
			res     <= skip_s3 ? s012_s3 : apt_pkg::fp_add(m3_s3, s012_s3);
		end
	end
endmodule

/* hw/rtl/affine_point_transform.sv */
// Top level of the affine point transform: config registers, three row
// lanes, valid pipeline and output merge. Depends on apt_pkg and apt_lane.
//
// Usage:
//  - Input channel in_valid/in_stall carries one point item (x, y, z float
//    bits and skip_translation). An item is taken when in_valid is high and
//    in_stall is low.
//  - Output channel out_valid/out_stall returns one item with the three
//    transformed coordinates; it is taken when out_valid && !out_stall.
//  - Six 64-bit matrix registers are written through cfg_we/cfg_idx/
//    cfg_wdata; an index past the last register is ignored.
//  - Throughput: one item per cycle while out_stall does not hold the
//    pipeline; each row lane holds one multiply stage and three add
//    stages, all running side by side, and out_valid follows the item
//    through the valid pipeline.
//  - When the receiver stalls a valid output, the whole pipeline holds and
//    in_stall rises, so no item is dropped; the output item stays put until taken.
//  - Reset clears the valid pipeline and loads the identity matrix.
//  - NaN results leave as the quiet NaN 0x7FC00000.
module affine_point_transform (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  apt_pkg::in_item_t             in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output apt_pkg::out_item_t            out_item,
	input  logic                          cfg_we,
	input  logic [apt_pkg::IdxW-1:0]      cfg_idx,
	input  logic [apt_pkg::RegW-1:0]      cfg_wdata
);
	logic [apt_pkg::RegW-1:0] regs_q [apt_pkg::NumRegs];
	logic [3:0]   vld_s;
	logic         adv;
	logic [31:0]  res [apt_pkg::NumLanes];

	// advance whenever the last stage is empty or being taken
	assign adv      = !(vld_s[3] && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[0] <= apt_pkg::RstRow0C01;
			regs_q[1] <= apt_pkg::RstRow0C23;
			regs_q[2] <= apt_pkg::RstRow1C01;
			regs_q[3] <= apt_pkg::RstRow1C23;
			regs_q[4] <= apt_pkg::RstRow2C01;
			regs_q[5] <= apt_pkg::RstRow2C23;
			vld_s     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					apt_pkg::RegRow0C01: regs_q[0] <= cfg_wdata;
					apt_pkg::RegRow0C23: regs_q[1] <= cfg_wdata;
					apt_pkg::RegRow1C01: regs_q[2] <= cfg_wdata;
					apt_pkg::RegRow1C23: regs_q[3] <= cfg_wdata;
					apt_pkg::RegRow2C01: regs_q[4] <= cfg_wdata;
					apt_pkg::RegRow2C23: regs_q[5] <= cfg_wdata;
					default: ;
				endcase
			end
			if (adv)
				vld_s <= {vld_s[2:0], in_valid};
		end
	end

	for (genvar l = 0; l < apt_pkg::NumLanes; l++) begin : g_lane
		apt_pkg::row_t row;
		assign row = {regs_q[2*l+1], regs_q[2*l]};
		apt_lane u_lane (
			.clk    (clk),
			.en     (adv),
			.row    (row),
			.pt     (in_item),
			.res    (res[l])
		);
	end

	// merge the lanes into one output item
	assign out_valid      = vld_s[3];
	assign out_item.out_x = res[0];
	assign out_item.out_y = res[1];
	assign out_item.out_z = res[2];
endmodule

/* hw/rtl/apt_checker.sv */
// Port checker for the affine point transform and its bind.
// Depends on apt_pkg and affine_point_transform.
module apt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input apt_pkg::out_item_t out_item
);
	// hold a stalled output item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("output item changed under stall");

	// input stall only while the output is stalled
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// an accepted item is offered at the output after the valid pipeline if nothing stalls
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall |=> out_valid)
		else $error("item lost in pipeline");
endmodule

bind affine_point_transform apt_checker u_apt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
